// ===== rtl/scfb_pkg.sv =====
package scfb_pkg;

	localparam int MAX_CHANNELS = 10;
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [0:0] REG_FRAME_MODE = 1'b0;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_SEND = 1'b1;

	localparam logic MODE_FLOAT_TAIL = 1'b0;
	localparam logic MODE_DOLLAR     = 1'b1;

	localparam logic [7:0] HEADER_BYTE = 8'h24;
	localparam logic [7:0] TAIL_B0     = 8'h00;
	localparam logic [7:0] TAIL_B1     = 8'h00;
	localparam logic [7:0] TAIL_B2     = 8'h80;
	localparam logic [7:0] TAIL_B3     = 8'h7f;

	// which byte source the datapath loads into the output register
	localparam logic [1:0] KIND_HEAD = 2'd0;
	localparam logic [1:0] KIND_WORD = 2'd1;
	localparam logic [1:0] KIND_TAIL = 2'd2;
	localparam logic [1:0] KIND_LEN  = 2'd3;

	typedef struct packed {
		logic       add;
		logic       send;
		logic       emit;
		logic [1:0] kind;
	} scfb_cmd_t;

	typedef struct packed {
		logic frame_ok;
		logic word_last;
		logic byte_last;
		logic out_free;
	} scfb_status_t;

endpackage

// ===== rtl/scfb_in_if.sv =====
interface scfb_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] sample_bits;

	modport source (output valid, output command, output sample_bits, input ready);
	modport sink (input valid, input command, input sample_bits, output ready);
endinterface

// ===== rtl/scfb_out_if.sv =====
interface scfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== rtl/scfb_ctrl.sv =====
module scfb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_command,
	output logic                  in_ready,
	input  logic                  frame_mode,
	input  scfb_pkg::scfb_status_t status,
	output scfb_pkg::scfb_cmd_t    cmd
);
	import scfb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HEAD = 2'd1;
	localparam logic [1:0] ST_WORD = 2'd2;
	localparam logic [1:0] ST_TAIL = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.add  = accept && (in_command == CMD_ADD);
		cmd.send = accept && (in_command == CMD_SEND);
		cmd.emit = (state_q != ST_IDLE) && status.out_free;
		case (state_q)
			ST_HEAD: cmd.kind = KIND_HEAD;
			ST_WORD: cmd.kind = KIND_WORD;
			ST_TAIL: cmd.kind = (frame_mode == MODE_DOLLAR) ? KIND_LEN : KIND_TAIL;
			default: cmd.kind = KIND_HEAD;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.send && status.frame_ok)
					state_d = (frame_mode == MODE_DOLLAR) ? ST_HEAD : ST_WORD;
			end
			ST_HEAD: begin
				if (cmd.emit)
					state_d = ST_WORD;
			end
			ST_WORD: begin
				if (cmd.emit && status.byte_last && status.word_last)
					state_d = ST_TAIL;
			end
			ST_TAIL: begin
				// length byte is a single byte, float tail runs four
				if (cmd.emit && (frame_mode == MODE_DOLLAR || status.byte_last))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/scfb_datapath.sv =====
module scfb_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [31:0]            sample_bits,
	input  scfb_pkg::scfb_cmd_t    cmd,
	output scfb_pkg::scfb_status_t status,
	scfb_out_if.source             byte_out
);
	import scfb_pkg::*;

	logic [31:0]      store_q [MAX_CHANNELS];
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] len_q;
	logic [IDX_W-1:0] widx_q;
	logic [1:0]       bsel_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [31:0]      word_q;
	logic [7:0]       word_byte;
	logic [7:0]       tail_byte;
	logic [7:0]       next_byte;
	logic             next_last;

	assign status.frame_ok  = (count_q != '0) && !ovf_q;
	assign status.word_last = (CNT_W'(widx_q) == len_q - 1'b1);
	assign status.byte_last = (bsel_q == 2'd3);
	assign status.out_free  = !out_valid_q || byte_out.ready;

	// channel store, written only while there is room
	always_ff @(posedge clk) begin
		if (cmd.add && count_q < CNT_W'(MAX_CHANNELS))
			store_q[count_q[IDX_W-1:0]] <= sample_bits;
	end

	// word register, loaded with the first word on send and the next one on the last byte
	always_ff @(posedge clk) begin
		if (cmd.send)
			word_q <= store_q[IDX_W'(0)];
		else if (cmd.emit && cmd.kind == KIND_WORD && status.byte_last && !status.word_last)
			word_q <= store_q[widx_q + 1'b1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.add) begin
			if (count_q < CNT_W'(MAX_CHANNELS))
				count_q <= count_q + 1'b1;
			else
				ovf_q <= 1'b1;
		end else if (cmd.send) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end
	end

	// frame length and byte cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			widx_q <= '0;
			bsel_q <= '0;
		end else if (cmd.send) begin
			len_q  <= count_q;
			widx_q <= '0;
			bsel_q <= '0;
		end else if (cmd.emit && (cmd.kind == KIND_WORD || cmd.kind == KIND_TAIL)) begin
			bsel_q <= bsel_q + 1'b1;
			if (cmd.kind == KIND_WORD && status.byte_last)
				widx_q <= status.word_last ? '0 : widx_q + 1'b1;
		end
	end

	always_comb begin
		case (bsel_q)
			2'd0: word_byte = word_q[7:0];
			2'd1: word_byte = word_q[15:8];
			2'd2: word_byte = word_q[23:16];
			2'd3: word_byte = word_q[31:24];
			default: word_byte = word_q[7:0];
		endcase
		case (bsel_q)
			2'd0: tail_byte = TAIL_B0;
			2'd1: tail_byte = TAIL_B1;
			2'd2: tail_byte = TAIL_B2;
			2'd3: tail_byte = TAIL_B3;
			default: tail_byte = TAIL_B0;
		endcase
		case (cmd.kind)
			KIND_HEAD: next_byte = HEADER_BYTE;
			KIND_WORD: next_byte = word_byte;
			KIND_TAIL: next_byte = tail_byte;
			KIND_LEN:  next_byte = 8'({len_q, 2'b01});
			default:   next_byte = HEADER_BYTE;
		endcase
		next_last = (cmd.kind == KIND_LEN) || (cmd.kind == KIND_TAIL && status.byte_last);
	end

	// output register, refilled in the same cycle the held item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (byte_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_q <= next_byte;
			last_q <= next_last;
		end
	end

	assign byte_out.valid      = out_valid_q;
	assign byte_out.frame_byte = byte_q;
	assign byte_out.last_byte  = last_q;

endmodule

// ===== rtl/scope_channel_frame_builder_core.sv =====
// channel    dir  handshake             payload
// item_in    in   valid/ready           command, sample_bits[31:0]
// byte_out   out  valid/ready           frame_byte[7:0], last_byte
// apb        in   psel/penable/pready   paddr[2:0], pwdata/prdata[31:0]
//
// an add item leaves the sequencer idle, so adds may arrive back to back
// a send with n stored words streams 4*n+2 bytes (dollar header) or 4*n+4 bytes
// (float tail), one a cycle through the output register while byte_out is ready;
// item_in is not ready until the sequencer has loaded the last byte
// an empty send or a send after overflow emits nothing and leaves item_in ready
// a held output byte stalls the sequencer; nothing is dropped
// arst_n clears count, overflow mark, mode and sequencer; store contents stay undefined
module scope_channel_frame_builder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	scfb_in_if.sink                           item_in,
	scfb_out_if.source                        byte_out,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [scfb_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [scfb_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [scfb_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import scfb_pkg::*;

	logic         mode_q;
	logic [0:0]   reg_idx;
	logic         reg_hit;
	scfb_cmd_t    cmd;
	scfb_status_t status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign reg_hit = (reg_idx == REG_FRAME_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_FLOAT_TAIL;
		else if (psel && penable && pwrite && pready && reg_hit)
			mode_q <= pwdata[0];
	end

	assign prdata = reg_hit ? APB_DATA_W'(mode_q) : '0;

	scfb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item_in.valid),
		.in_command (item_in.command),
		.in_ready   (item_in.ready),
		.frame_mode (mode_q),
		.status     (status),
		.cmd        (cmd)
	);

	scfb_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_bits (item_in.sample_bits),
		.cmd         (cmd),
		.status      (status),
		.byte_out    (byte_out)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import scfb_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_MODE = APB_ADDR_W'(REG_FRAME_MODE) << 2;
	// one register slot past the last one, never decoded
	localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = ADDR_FRAME_MODE + APB_ADDR_W'(4);
	localparam int RANDOM_ITEMS = 445;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_byte_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	scfb_in_if item_if ();
	scfb_out_if byte_if ();

	scope_channel_frame_builder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_if),
		.byte_out (byte_if),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// own copy of the block state
	logic [31:0] chan_words [MAX_CHANNELS];
	int unsigned chan_count;
	bit          chan_overflow;
	logic        frame_mode_model;

	frame_byte_t expected_bytes [$];
	int          mismatch_count;
	int          items_sent;
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic void push_byte(input logic [7:0] fb, input logic last);
		expected_bytes.push_back('{frame_byte: fb, last_byte: last});
	endfunction

	function automatic void predict_frame(input logic cmd, input logic [31:0] bits);
		if (cmd == CMD_ADD) begin
			if (chan_count >= MAX_CHANNELS)
				chan_overflow = 1'b1;
			else begin
				chan_words[chan_count] = bits;
				chan_count++;
			end
			return;
		end
		if (chan_count != 0 && !chan_overflow) begin
			if (frame_mode_model == MODE_DOLLAR)
				push_byte(HEADER_BYTE, 1'b0);
			for (int i = 0; i < chan_count; i++)
				for (int b = 0; b < 4; b++)
					push_byte(chan_words[i][8*b +: 8], 1'b0);
			if (frame_mode_model == MODE_DOLLAR) begin
				push_byte(8'(4 * chan_count + 1), 1'b1);
			end else begin
				push_byte(TAIL_B0, 1'b0);
				push_byte(TAIL_B1, 1'b0);
				push_byte(TAIL_B2, 1'b0);
				push_byte(TAIL_B3, 1'b1);
			end
		end
		chan_count = 0;
		chan_overflow = 1'b0;
	endfunction

	// output check first, then prediction of the item taken at the same edge
	always @(posedge clk) begin
		frame_byte_t exp_byte;
		if (arst_n) begin
			if (byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", byte_if.frame_byte));
				end else begin
					exp_byte = expected_bytes.pop_front();
					if (byte_if.frame_byte !== exp_byte.frame_byte)
						report_mismatch($sformatf("frame_byte got %02h want %02h",
							byte_if.frame_byte, exp_byte.frame_byte));
					if (byte_if.last_byte !== exp_byte.last_byte)
						report_mismatch($sformatf("last_byte got %b want %b",
							byte_if.last_byte, exp_byte.last_byte));
				end
			end
			if (item_if.valid === 1'b1 && item_if.ready === 1'b1)
				predict_frame(item_if.command, item_if.sample_bits);
		end
	end

	// byte receiver with a fresh stall drawn for every item
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				@(negedge clk);
				byte_if.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			byte_if.ready <= 1'b1;
			do @(posedge clk); while (byte_if.valid !== 1'b1);
		end
	end

	task automatic send_item(input logic cmd, input logic [31:0] bits);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk);
			item_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_if.valid <= 1'b1;
		item_if.command <= cmd;
		item_if.sample_bits <= bits;
		do @(posedge clk); while (item_if.ready !== 1'b1);
		items_sent++;
	endtask

	// stop sending and let every expected byte drain out
	task automatic settle();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == ADDR_FRAME_MODE)
			frame_mode_model = data[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_frame_mode();
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_FRAME_MODE;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		if (rd[0] !== frame_mode_model)
			report_mismatch($sformatf("frame_mode read %b want %b", rd[0], frame_mode_model));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h7f80_0000;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_send();
		check_frame_mode();
		send_item(CMD_SEND, 32'hffff_ffff);
		settle();
	endtask

	task automatic test_float_tail_frame();
		send_item(CMD_ADD, 32'hffff_ffff);
		send_item(CMD_ADD, 32'h0000_0000);
		send_item(CMD_SEND, 32'h0000_0000);
		settle();
	endtask

	task automatic test_dollar_frame();
		apb_write(ADDR_FRAME_MODE, 32'(MODE_DOLLAR));
		check_frame_mode();
		send_item(CMD_ADD, 32'h8000_0001);
		send_item(CMD_SEND, 32'h0);
		settle();
	endtask

	task automatic test_store_overflow();
		// one word past a full store kills the frame
		repeat (MAX_CHANNELS + 1) send_item(CMD_ADD, $urandom);
		send_item(CMD_SEND, $urandom);
		// count and mark are cleared by that send
		send_item(CMD_ADD, 32'h3f80_0000);
		send_item(CMD_SEND, $urandom);
		settle();
	endtask

	task automatic test_spare_register();
		apb_write(ADDR_SPARE, 32'(MODE_FLOAT_TAIL));
		check_frame_mode();
		send_item(CMD_ADD, 32'h1234_5678);
		send_item(CMD_SEND, 32'h0);
		settle();
		apb_write(ADDR_FRAME_MODE, 32'(MODE_FLOAT_TAIL));
		check_frame_mode();
	endtask

	task automatic test_random_frames();
		int start;
		int n_words;
		int pick;
		int frames;
		start = items_sent;
		frames = 0;
		while (items_sent - start < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 19);
			if (pick == 0)
				n_words = 0;
			else if (pick == 1)
				n_words = $urandom_range(MAX_CHANNELS + 1, MAX_CHANNELS + 3);
			else if (pick <= 4)
				n_words = MAX_CHANNELS;
			else
				n_words = $urandom_range(1, MAX_CHANNELS - 1);
			for (int i = 0; i < n_words; i++) begin
				// stray items break the sequence now and then
				if ($urandom_range(0, 15) == 0)
					send_item(logic'($urandom_range(0, 1)), $urandom);
				send_item(CMD_ADD, pick_word());
			end
			send_item(CMD_SEND, $urandom);
			frames++;
			if (frames % 8 == 0) begin
				settle();
				apb_write(ADDR_FRAME_MODE, $urandom);
				if ($urandom_range(0, 3) == 0)
					apb_write(ADDR_SPARE, $urandom);
				check_frame_mode();
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.command = CMD_ADD;
		item_if.sample_bits = '0;
		byte_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		chan_count = 0;
		chan_overflow = 1'b0;
		frame_mode_model = MODE_FLOAT_TAIL;
		mismatch_count = 0;
		items_sent = 0;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_send();
		test_float_tail_frame();
		test_dollar_frame();
		test_store_overflow();
		test_spare_register();
		test_random_frames();

		settle();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && expected_bytes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
